FILE: rtl/canf_pkg.sv
// canf_pkg: word types, register indexes and constants shared by the
// CAN identifier filter with per-identifier rate limit and its checker
// no dependencies
`default_nettype none

package canf_pkg;

  localparam int ID_W    = 29;
  localparam int TIME_W  = 32;
  localparam int SLOT_W  = 7;
  localparam int COUNT_W = 8;
  localparam int CFG_W   = 32;
  localparam int CFG_IDX_W = 2;

  // register indexes on the configuration port
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_INTERVAL = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ENTRY_COUNT  = 2'd1;

  // input word actions
  localparam logic ACT_FILTER = 1'b0;
  localparam logic ACT_LOAD   = 1'b1;

  // reset gap: one frame per 1/11 s
  localparam logic [TIME_W-1:0] MIN_INTERVAL_RST = TIME_W'(1000000 / 11);

  typedef struct packed {
    logic              action;
    logic [ID_W-1:0]   frame_id;
    logic [TIME_W-1:0] time_us;
    logic [SLOT_W-1:0] entry_index;
  } in_word_t;

  typedef struct packed {
    logic pass;
    logic matched;
  } out_word_t;

  // one table slot: identifier and time of the last passed frame
  typedef struct packed {
    logic [ID_W-1:0]   id;
    logic [TIME_W-1:0] stamp;
  } entry_t;

endpackage

`default_nettype wire

FILE: rtl/canf_rate_chk.sv
// canf_rate_chk: shared rate unit, wrapping time difference against the gap
// depends on canf_pkg
`default_nettype none

module canf_rate_chk (
  input  wire logic [canf_pkg::TIME_W-1:0] now_us,
  input  wire logic [canf_pkg::TIME_W-1:0] last_us,
  input  wire logic [canf_pkg::TIME_W-1:0] min_gap,
  output logic                             gap_ok
);
  import canf_pkg::*;

  logic [TIME_W-1:0] elapsed;

  // modulo 2^32 difference, then unsigned compare
  assign elapsed = now_us - last_us;
  assign gap_ok  = (elapsed >= min_gap);

endmodule

`default_nettype wire

FILE: rtl/can_id_filter_rate_limiter_top.sv
// can_id_filter_rate_limiter_top: identifier whitelist with a per-identifier
// rate limit, one table memory scanned by a small sequencer
// depends on canf_pkg, canf_rate_chk
//
// For a load word busy stays low and the result strobe (pass and matched
// both 0) follows in the next cycle. A frame word raises busy while slots
// are read one per cycle from the table memory (one read port, one write
// port) and compared in order, each in the cycle after its read. The scan
// covers n = min(entry_count, TABLE_DEPTH) slots; a match ends it and
// gives the result strobe, a frame that matches no slot gives it after the
// last slot is compared, and busy drops with the strobe.
// The longest scan reads every slot in turn through the one read port.
// After reset a clearing pass zeroes every slot, identifier and last-pass
// time, with busy high; configuration writes are taken at any time. Each
// result is on out_word for exactly one cycle with out_valid and cannot be
// held off, so the receiver must take it in that cycle.
`default_nettype none

module can_id_filter_rate_limiter_top #(
  parameter int TABLE_DEPTH = 128
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          start,
  output logic                               busy,
  input  wire canf_pkg::in_word_t            in_word,
  output logic                               out_valid,
  output canf_pkg::out_word_t                out_word,
  input  wire logic                          cfg_we,
  input  wire logic [canf_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [canf_pkg::CFG_W-1:0]     cfg_wdata
);
  import canf_pkg::*;

  localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_CLEAR = 2'd1;
  localparam logic [1:0] ST_SCAN  = 2'd2;
  localparam logic [1:0] ST_CHECK = 2'd3;

  logic [1:0]        state_r, state_nxt;
  logic [TIME_W-1:0] min_interval_r;
  logic [COUNT_W-1:0] entry_count_r;
  logic [CNT_W-1:0]  issue_r, issue_nxt;
  logic [CNT_W-1:0]  limit_r, limit_nxt;
  logic [IDX_W-1:0]  rd_idx_r;
  logic              rd_vld_r, rd_vld_nxt;
  logic [ID_W-1:0]   fid_r;
  logic [TIME_W-1:0] ts_r;
  entry_t            rdata_r;
  logic              out_valid_r, out_valid_nxt;
  out_word_t         out_word_r, out_word_nxt;

  entry_t            mem [TABLE_DEPTH];
  logic              mem_we;
  logic [IDX_W-1:0]  mem_waddr;
  entry_t            mem_wdata;
  logic              rd_en;
  logic [IDX_W-1:0]  rd_addr;

  logic              accept;
  logic              hit;
  logic              gap_ok;

  assign busy   = !rst_n || (state_r != ST_IDLE);
  assign accept = start && !busy;
  assign hit    = (state_r == ST_SCAN) && rd_vld_r && (rdata_r.id == fid_r);
  assign rd_addr = issue_r[IDX_W-1:0];

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_interval_r <= MIN_INTERVAL_RST;
      entry_count_r  <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_MIN_INTERVAL: min_interval_r <= cfg_wdata;
        CFG_ENTRY_COUNT:  entry_count_r  <= cfg_wdata[COUNT_W-1:0];
        default: ;
      endcase
    end
  end

  // shared rate unit on the matched slot
  canf_rate_chk u_rate (
    .now_us  (ts_r),
    .last_us (rdata_r.stamp),
    .min_gap (min_interval_r),
    .gap_ok  (gap_ok)
  );

  // sequencer
  always_comb begin
    state_nxt     = state_r;
    issue_nxt     = issue_r;
    limit_nxt     = limit_r;
    rd_vld_nxt    = 1'b0;
    rd_en         = 1'b0;
    mem_we        = 1'b0;
    mem_waddr     = issue_r[IDX_W-1:0];
    mem_wdata     = '0;
    out_valid_nxt = 1'b0;
    out_word_nxt  = '0;

    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          if (in_word.action == ACT_LOAD) begin
            // slots past the table are ignored
            mem_we          = (32'(in_word.entry_index) < 32'(TABLE_DEPTH));
            mem_waddr       = IDX_W'(in_word.entry_index);
            mem_wdata.id    = in_word.frame_id;
            mem_wdata.stamp = '0;
            out_valid_nxt   = 1'b1;
          end else begin
            issue_nxt = '0;
            limit_nxt = (32'(entry_count_r) > 32'(TABLE_DEPTH)) ?
                        CNT_W'(TABLE_DEPTH) : CNT_W'(entry_count_r);
            state_nxt = ST_SCAN;
          end
        end
      end

      ST_CLEAR: begin
        mem_we    = 1'b1;
        issue_nxt = issue_r + 1'b1;
        if (issue_r == CNT_W'(TABLE_DEPTH - 1)) begin
          state_nxt = ST_IDLE;
        end
      end

      ST_SCAN: begin
        // one read per cycle until hit or limit, compared in the next cycle
        if (hit) begin
          state_nxt = ST_CHECK;
        end else if (issue_r != limit_r) begin
          rd_en      = 1'b1;
          rd_vld_nxt = 1'b1;
          issue_nxt  = issue_r + 1'b1;
        end else if (!rd_vld_r) begin
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end

      ST_CHECK: begin
        mem_we               = gap_ok;
        mem_waddr            = rd_idx_r;
        mem_wdata.id         = rdata_r.id;
        mem_wdata.stamp      = ts_r;
        out_valid_nxt        = 1'b1;
        out_word_nxt.matched = 1'b1;
        out_word_nxt.pass    = gap_ok;
        state_nxt            = ST_IDLE;
      end

      default: state_nxt = ST_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      issue_r     <= '0;
      limit_r     <= '0;
      rd_vld_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      issue_r     <= issue_nxt;
      limit_r     <= limit_nxt;
      rd_vld_r    <= rd_vld_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // frame word and result payload
  always_ff @(posedge clk) begin
    if (accept) begin
      fid_r <= in_word.frame_id;
      ts_r  <= in_word.time_us;
    end
    out_word_r <= out_word_nxt;
  end

  // table memory: one write, one registered read
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rdata_r  <= mem[rd_addr];
      rd_idx_r <= rd_addr;
    end
  end

  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

endmodule

`default_nettype wire

FILE: rtl/canf_checker.sv
// canf_checker: port-level assertions for the CAN filter top level,
// attached by the bind at the end of this file
// depends on canf_pkg, can_id_filter_rate_limiter_top
`default_nettype none

module canf_checker (
  input wire logic                           clk,
  input wire logic                           rst_n,
  input wire logic                           start,
  input wire logic                           busy,
  input wire canf_pkg::in_word_t             in_word,
  input wire logic                           out_valid,
  input wire canf_pkg::out_word_t            out_word
);
  import canf_pkg::*;

  // clearing pass holds the block busy after reset
  a_clear_after_reset: assert property (@(posedge clk) !rst_n |=> busy)
    else $error("busy low right after reset");

  // a load word answers in the next cycle with an empty result
  a_load_result: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && in_word.action == ACT_LOAD) |=>
      (out_valid && !out_word.pass && !out_word.matched))
    else $error("load word without empty result");

  // a frame word starts a scan
  a_frame_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && in_word.action == ACT_FILTER) |=> (busy && !out_valid))
    else $error("frame word did not start a scan");

  // a passed frame must have matched a slot
  a_pass_matched: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_word.pass) |-> out_word.matched)
    else $error("pass without match");

endmodule

bind can_id_filter_rate_limiter_top canf_checker u_canf_checker (.*);

`default_nettype wire
